// ===== hdl/pip_pkg.sv =====
// Shared types for the point-in-polygon test: opcodes and the command and
// status groups that pass between the controller and the datapath.
// No dependencies.
`default_nettype none

package pip_pkg;

	// Item opcodes; the fourth code is ignored
	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2
	} pip_op_t;

	// Controller to datapath
	typedef struct packed {
		logic clear;       // empty the polygon, drop the overflow mark
		logic append;      // store one vertex, or flag it as dropped
		logic load_query;  // latch the query point, clear the parity
		logic emit_empty;  // give an outside answer at once (no vertices)
		logic prime;       // read the last vertex as the first "previous"
		logic step;        // read the next vertex and walk one edge
	} pip_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic count_zero;    // no vertices stored
		logic idx_last;      // walk index is on the last stored vertex
		logic result_valid;  // result is on the ports this cycle
	} pip_status_t;

endpackage

`default_nettype wire

// ===== hdl/pip_ctrl.sv =====
// Controller for the point-in-polygon test: decodes items and sequences the
// edge walk of a query. Depends on pip_pkg.
`default_nettype none

module pip_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [1:0]          opcode,
	input  wire pip_pkg::pip_status_t status,
	output pip_pkg::pip_cmd_t        cmd,
	output logic                     busy
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRIME,
		ST_WALK,
		ST_WAIT
	} state_t;

	state_t state_q;
	logic   busy_q;

	assign busy = busy_q;

	// Commands follow from the state and the item on offer
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (opcode)
						pip_pkg::OP_CLEAR:  cmd.clear = 1'b1;
						pip_pkg::OP_APPEND: cmd.append = 1'b1;
						pip_pkg::OP_QUERY: begin
							cmd.load_query = 1'b1;
							cmd.emit_empty = status.count_zero;
						end
						default: ;
					endcase
				end
			end
			ST_PRIME: cmd.prime = 1'b1;
			ST_WALK:  cmd.step = 1'b1;
			ST_WAIT:  ;
			default:  ;
		endcase
	end

	// State and busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start && opcode == pip_pkg::OP_QUERY) begin
						busy_q  <= 1'b1;
						state_q <= status.count_zero ? ST_WAIT : ST_PRIME;
					end
				end
				ST_PRIME: state_q <= ST_WALK;
				ST_WALK: begin
					if (status.idx_last)
						state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (status.result_valid) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/pip_datapath.sv =====
// Datapath for the point-in-polygon test: vertex store, walk index, the
// three-stage edge pipeline and the parity. Depends on pip_pkg.
`default_nettype none

module pip_datapath #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS   = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire pip_pkg::pip_cmd_t            cmd,
	input  wire logic signed [COORD_BITS-1:0] coord_x,
	input  wire logic signed [COORD_BITS-1:0] coord_y,
	output pip_pkg::pip_status_t              status,
	output logic                              inside_res,
	output logic                              vertices_dropped
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;

	// Vertex store
	logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
	logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];

	logic [CW-1:0] count_q;
	logic          overflow_q;
	logic [AW-1:0] rd_idx_q;
	logic [AW-1:0] last_addr;
	logic [AW-1:0] rd_addr;
	logic          full;

	logic signed [COORD_BITS-1:0] qx_q, qy_q;
	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;

	// Stage 1: read data
	logic signed [COORD_BITS-1:0] rdx_s1, rdy_s1;
	logic                         prime_s1, edge_s1, last_s1;

	// Stage 2: differences
	logic signed [DW-1:0] dqx_s2, dy_s2, dxji_s2, dqy_s2;
	logic                 strad_s2, dypos_s2, edge_s2, last_s2;

	// Stage 3: products
	logic signed [PW-1:0] lhs_s3, rhs_s3;
	logic                 strad_s3, dypos_s3, edge_s3, last_s3;

	logic parity_q;
	logic flip;
	logic res_valid_q;
	logic inside_q;

	assign full      = (count_q == CW'(MAX_VERTICES));
	assign last_addr = AW'(count_q - CW'(1));
	assign rd_addr   = cmd.prime ? last_addr : rd_idx_q;

	assign status.count_zero   = (count_q == '0);
	assign status.idx_last     = (rd_idx_q == last_addr);
	assign status.result_valid = res_valid_q;

	assign inside_res       = inside_q;
	assign vertices_dropped = overflow_q;

	// Store write on append
	always_ff @(posedge clk) begin
		if (cmd.append && !full) begin
			mem_x[count_q[AW-1:0]] <= coord_x;
			mem_y[count_q[AW-1:0]] <= coord_y;
		end
	end

	// Registered store read
	always_ff @(posedge clk) begin
		if (cmd.prime || cmd.step) begin
			rdx_s1 <= mem_x[rd_addr];
			rdy_s1 <= mem_y[rd_addr];
		end
	end

	// Vertex count, overflow mark and walk index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
			rd_idx_q   <= '0;
		end else begin
			if (cmd.clear) begin
				count_q    <= '0;
				overflow_q <= 1'b0;
			end else if (cmd.append) begin
				if (full)
					overflow_q <= 1'b1;
				else
					count_q <= count_q + CW'(1);
			end
			if (cmd.prime)
				rd_idx_q <= '0;
			else if (cmd.step)
				rd_idx_q <= rd_idx_q + AW'(1);
		end
	end

	// Query point
	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			qx_q <= coord_x;
			qy_q <= coord_y;
		end
	end

	// Previous vertex follows each vertex read out
	always_ff @(posedge clk) begin
		if (prime_s1 || edge_s1) begin
			prev_x_q <= rdx_s1;
			prev_y_q <= rdy_s1;
		end
	end

	// Edge i runs from the current vertex (i) back to the previous one (j)
	always_ff @(posedge clk) begin
		dqx_s2   <= {qx_q[COORD_BITS-1], qx_q} - {rdx_s1[COORD_BITS-1], rdx_s1};
		dy_s2    <= {prev_y_q[COORD_BITS-1], prev_y_q} - {rdy_s1[COORD_BITS-1], rdy_s1};
		dxji_s2  <= {prev_x_q[COORD_BITS-1], prev_x_q} - {rdx_s1[COORD_BITS-1], rdx_s1};
		dqy_s2   <= {qy_q[COORD_BITS-1], qy_q} - {rdy_s1[COORD_BITS-1], rdy_s1};
		strad_s2 <= (rdy_s1 > qy_q) != (prev_y_q > qy_q);
		dypos_s2 <= prev_y_q > rdy_s1;
	end

	// Cross products, exact
	always_ff @(posedge clk) begin
		lhs_s3   <= dqx_s2 * dy_s2;
		rhs_s3   <= dxji_s2 * dqy_s2;
		strad_s3 <= strad_s2;
		dypos_s3 <= dypos_s2;
	end

	// Sign-corrected compare: point lies left of the crossing
	assign flip = edge_s3 && strad_s3 &&
		(dypos_s3 ? (lhs_s3 < rhs_s3) : (rhs_s3 < lhs_s3));

	// Pipeline control, parity and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_s1    <= 1'b0;
			edge_s1     <= 1'b0;
			last_s1     <= 1'b0;
			edge_s2     <= 1'b0;
			last_s2     <= 1'b0;
			edge_s3     <= 1'b0;
			last_s3     <= 1'b0;
			parity_q    <= 1'b0;
			res_valid_q <= 1'b0;
			inside_q    <= 1'b0;
		end else begin
			prime_s1 <= cmd.prime;
			edge_s1  <= cmd.step;
			last_s1  <= cmd.step && status.idx_last;
			edge_s2  <= edge_s1;
			last_s2  <= last_s1;
			edge_s3  <= edge_s2;
			last_s3  <= last_s2;

			res_valid_q <= 1'b0;
			if (cmd.load_query)
				parity_q <= 1'b0;
			else
				parity_q <= parity_q ^ flip;

			if (cmd.emit_empty) begin
				res_valid_q <= 1'b1;
				inside_q    <= 1'b0;
			end else if (last_s3) begin
				res_valid_q <= 1'b1;
				inside_q    <= parity_q ^ flip;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/point_in_polygon_test.sv =====
// Point-in-polygon test by crossing parity; top level joining pip_ctrl and
// pip_datapath. Depends on pip_pkg.
// Clear and append items are taken without raising busy. A query shows its
// result after a priming read, one store read per edge, two more pipeline
// stages and the result register, and busy drops the cycle after; a new
// query is taken only once busy is low. A query on an empty polygon shows
// its result in the next cycle. The receiver cannot stall; each result
// shows for one cycle with done. Reset empties the polygon and clears the
// overflow mark; the store contents are not cleared.
`default_nettype none

module point_in_polygon_test #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS   = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [1:0]                   opcode,
	input  wire logic signed [COORD_BITS-1:0] coord_x,
	input  wire logic signed [COORD_BITS-1:0] coord_y,
	output logic                              done,
	output logic                              inside_res,
	output logic                              vertices_dropped
);

	pip_pkg::pip_cmd_t    cmd;
	pip_pkg::pip_status_t status;

	assign done = status.result_valid;

	pip_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	pip_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_BITS   (COORD_BITS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.coord_x          (coord_x),
		.coord_y          (coord_y),
		.status           (status),
		.inside_res       (inside_res),
		.vertices_dropped (vertices_dropped)
	);

endmodule

`default_nettype wire

// ===== tb/point_in_polygon_test_tb.sv =====
// Self-checking testbench for point_in_polygon_test: builds polygons with clear and append
// items, queries points, and checks each answer against a crossing-parity predictor.
// Depends on pip_pkg and point_in_polygon_test.

module point_in_polygon_test_tb;

	localparam int MAX_VERTICES = 64;
	localparam int COORD_BITS   = 16;
	localparam logic [1:0] OP_IGNORED = 2'd3;
	localparam int TARGET_ITEMS = 1700;
	// longest query walk plus pipeline, with margin
	localparam int DRAIN_CYCLES = MAX_VERTICES + 16;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	localparam coord_t COORD_MIN = coord_t'(16'h8000);
	localparam coord_t COORD_MAX = coord_t'(16'h7FFF);

	typedef struct packed {
		logic in_poly;
		logic dropped;
	} answer_t;

	logic   clk        = 1'b0;
	logic   arst_n     = 1'b0;
	logic   start      = 1'b0;
	logic   [1:0] opcode = pip_pkg::OP_CLEAR;
	coord_t coord_x    = '0;
	coord_t coord_y    = '0;
	logic   busy;
	logic   done;
	logic   inside_res;
	logic   vertices_dropped;

	// answers owed by the block, oldest first
	answer_t expected_answers[$];

	// shadow polygon
	coord_t      poly_x [MAX_VERTICES];
	coord_t      poly_y [MAX_VERTICES];
	int unsigned poly_count    = 0;
	logic        poly_overflow = 1'b0;

	int mismatches = 0;
	int items_sent = 0;
	bit steady     = 1'b0;  // no idle gaps while set

	always #6 clk = ~clk;

	point_in_polygon_test #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_BITS  (COORD_BITS)
	) i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.opcode          (opcode),
		.coord_x         (coord_x),
		.coord_y         (coord_y),
		.done            (done),
		.inside_res      (inside_res),
		.vertices_dropped(vertices_dropped)
	);

	// Crossing parity of the shadow polygon for one point; exact cross-multiplication
	function automatic logic crossing_parity(input coord_t qx, input coord_t qy);
		logic        parity;
		int unsigned j;
		longint      xi, yi, xj, yj, dy, lhs, rhs;
		parity = 1'b0;
		for (int unsigned i = 0; i < poly_count; i++) begin
			j  = (i == 0) ? poly_count - 1 : i - 1;
			xi = longint'(poly_x[i]);
			yi = longint'(poly_y[i]);
			xj = longint'(poly_x[j]);
			yj = longint'(poly_y[j]);
			if ((yi > longint'(qy)) != (yj > longint'(qy))) begin
				dy  = yj - yi;
				lhs = (longint'(qx) - xi) * dy;
				rhs = (xj - xi) * (longint'(qy) - yi);
				if (dy > 0 ? (lhs < rhs) : (rhs < lhs))
					parity = ~parity;
			end
		end
		return parity;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (steady)
			return 0;
		roll = $urandom_range(99);
		if (roll < 65)
			return 0;
		if (roll < 95)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// span 0 means the full signed range
	function automatic coord_t pick_coord(input int span);
		int v;
		if (span == 0)
			return coord_t'($urandom);
		v = int'($urandom_range(2 * span)) - span;
		return coord_t'(v);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		mismatches++;
	endtask

	// Send one item, wait for it to be taken, then update the shadow
	task automatic send_item(input logic [1:0] op, input coord_t x, input coord_t y);
		int unsigned gap;
		answer_t     ans;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		opcode  <= op;
		coord_x <= x;
		coord_y <= y;
		do @(posedge clk); while (busy);
		case (op)
			pip_pkg::OP_CLEAR: begin
				poly_count    = 0;
				poly_overflow = 1'b0;
			end
			pip_pkg::OP_APPEND: begin
				if (poly_count < MAX_VERTICES) begin
					poly_x[poly_count] = x;
					poly_y[poly_count] = y;
					poly_count++;
				end else begin
					poly_overflow = 1'b1;
				end
			end
			pip_pkg::OP_QUERY: begin
				ans.in_poly = crossing_parity(x, y);
				ans.dropped = poly_overflow;
				expected_answers.push_back(ans);
			end
			default: ;
		endcase
		if (op != OP_IGNORED)
			items_sent++;
	endtask

	// Hold off until every answer is in, then let the block settle
	task automatic wait_idle();
		start <= 1'b0;
		while (expected_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Result checker
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && done) begin
			if (expected_answers.size() == 0) begin
				report_mismatch($sformatf("unexpected result inside=%0b dropped=%0b",
					inside_res, vertices_dropped));
			end else begin
				want = expected_answers.pop_front();
				if (inside_res !== want.in_poly)
					report_mismatch($sformatf("inside_res %0b, predicted %0b",
						inside_res, want.in_poly));
				if (vertices_dropped !== want.dropped)
					report_mismatch($sformatf("vertices_dropped %0b, predicted %0b",
						vertices_dropped, want.dropped));
			end
		end
	end

	// Queries with no vertices, plus an ignored opcode
	task automatic test_empty_polygon();
		send_item(pip_pkg::OP_QUERY, 16'sd0, 16'sd0);
		send_item(pip_pkg::OP_QUERY, COORD_MIN, COORD_MAX);
		send_item(OP_IGNORED, coord_t'(16'hFFFF), coord_t'(16'hFFFF));
		send_item(pip_pkg::OP_CLEAR, 16'sd0, 16'sd0);
		send_item(pip_pkg::OP_QUERY, COORD_MAX, COORD_MIN);
	endtask

	// Square on the extremes of the coordinate range; edges and corners probed
	task automatic test_extreme_square();
		send_item(pip_pkg::OP_CLEAR, coord_t'(16'h5555), coord_t'(16'hAAAA));
		send_item(pip_pkg::OP_APPEND, COORD_MIN, COORD_MIN);
		send_item(pip_pkg::OP_APPEND, COORD_MAX, COORD_MIN);
		send_item(pip_pkg::OP_APPEND, COORD_MAX, COORD_MAX);
		send_item(pip_pkg::OP_APPEND, COORD_MIN, COORD_MAX);
		send_item(pip_pkg::OP_QUERY, 16'sd0, 16'sd0);
		send_item(pip_pkg::OP_QUERY, COORD_MIN, 16'sd0);
		send_item(pip_pkg::OP_QUERY, COORD_MAX, COORD_MAX);
		send_item(OP_IGNORED, 16'sd1, 16'sd1);
		send_item(pip_pkg::OP_QUERY, 16'sd0, COORD_MIN);
	endtask

	// Triangle with a horizontal base, then one- and two-vertex polygons
	task automatic test_horizontal_and_degenerate();
		send_item(pip_pkg::OP_CLEAR, 16'sd0, 16'sd0);
		send_item(pip_pkg::OP_APPEND, 16'sd0, 16'sd0);
		send_item(pip_pkg::OP_APPEND, 16'sd100, 16'sd0);
		send_item(pip_pkg::OP_APPEND, 16'sd50, 16'sd100);
		send_item(pip_pkg::OP_QUERY, 16'sd50, 16'sd0);
		send_item(pip_pkg::OP_QUERY, 16'sd50, 16'sd50);
		send_item(pip_pkg::OP_CLEAR, 16'sd0, 16'sd0);
		send_item(pip_pkg::OP_APPEND, 16'sd10, 16'sd10);
		send_item(pip_pkg::OP_QUERY, 16'sd0, 16'sd10);
		send_item(pip_pkg::OP_APPEND, 16'sd30, -16'sd10);
		send_item(pip_pkg::OP_QUERY, 16'sd0, 16'sd0);
	endtask

	// Random polygons of random size and scale, each followed by a burst of queries
	task automatic test_random_polygons();
		int          polygons;
		int          roll;
		int          nverts;
		int          nqueries;
		int          span;
		int unsigned pick;
		coord_t      qx, qy;
		polygons = 0;
		while (items_sent < TARGET_ITEMS) begin
			steady = ($urandom_range(7) == 0);
			// a missing clear appends onto whatever is left
			if ($urandom_range(9) != 0)
				send_item(pip_pkg::OP_CLEAR, pick_coord(0), pick_coord(0));
			roll = $urandom_range(99);
			if (polygons == 0 || roll < 5)
				nverts = $urandom_range(MAX_VERTICES + 8, MAX_VERTICES - 4);
			else if (roll < 15)
				nverts = $urandom_range(2);
			else
				nverts = $urandom_range(10, 3);
			// small grids give ties on vertices and horizontal edges
			case ($urandom_range(2))
				0: span = 0;
				1: span = 1000;
				default: span = 12;
			endcase
			for (int v = 0; v < nverts; v++) begin
				if ($urandom_range(29) == 0)
					send_item(OP_IGNORED, pick_coord(0), pick_coord(0));
				send_item(pip_pkg::OP_APPEND, pick_coord(span), pick_coord(span));
			end
			nqueries = $urandom_range(8, 1);
			for (int q = 0; q < nqueries; q++) begin
				qx = pick_coord(span);
				qy = pick_coord(span);
				roll = $urandom_range(9);
				if (poly_count > 0 && roll < 2) begin
					pick = $urandom_range(poly_count - 1);
					qy = poly_y[pick];
					if (roll == 0)
						qx = poly_x[pick];
				end else if (roll == 2) begin
					qx = pick_coord(0);
					qy = pick_coord(0);
				end
				send_item(pip_pkg::OP_QUERY, qx, qy);
			end
			polygons++;
			if (polygons % 40 == 0)
				wait_idle();
		end
		steady = 1'b0;
	endtask

	// Run limit
	initial begin
		#(12 * 1000000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_polygon();
		test_extreme_square();
		test_horizontal_and_degenerate();
		wait_idle();
		test_random_polygons();
		wait_idle();
		if (mismatches == 0 && expected_answers.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
